@@ src/tdpt_pkg.sv @@
// shared constants and control/status types for the trial division prime test
package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 2;
  localparam int REM_WIDTH   = DIV_WIDTH + 1;
  localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

  localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(3);
  localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(9);
  localparam logic [SQ_WIDTH-1:0]  SQUARE_STEP   = SQ_WIDTH'(4);
  localparam logic [DIV_WIDTH-1:0] DIVISOR_STEP  = DIV_WIDTH'(2);

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic advance;
    logic out_load;
    logic res_val;
  } tdpt_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_is2;
    logic n_even;
    logic sq_gt_n;
    logic rem_zero;
    logic step_last;
  } tdpt_sts_t;

endpackage

@@ src/tdpt_if.sv @@
// valid/ready channel interfaces for candidate items and result items
interface tdpt_in_if import tdpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

@@ src/tdpt_dp.sv @@
// datapath: candidate, divisor, running square, bit-serial remainder, result register
module tdpt_dp import tdpt_pkg::*; (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] candidate,
  input  tdpt_cmd_t              cmd,
  output tdpt_sts_t              sts,
  output logic                   is_prime
);

  logic [VALUE_WIDTH-1:0] n_r;
  logic [DIV_WIDTH-1:0]   d_r;
  logic [SQ_WIDTH-1:0]    sq_r;
  logic [REM_WIDTH-1:0]   rem_r;
  logic [CNT_WIDTH-1:0]   bit_cnt_r;
  logic                   is_prime_r;

  logic [REM_WIDTH-1:0]   shifted;
  logic                   fits;

  assign shifted = {rem_r[REM_WIDTH-2:0], n_r[bit_cnt_r]};
  assign fits    = shifted >= REM_WIDTH'(d_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= candidate;
      d_r  <= FIRST_DIVISOR;
      sq_r <= FIRST_SQUARE;
    end else if (cmd.advance) begin
      d_r  <= d_r + DIVISOR_STEP;
      sq_r <= sq_r + SQ_WIDTH'({d_r, 2'b00}) + SQUARE_STEP;
    end

    if (cmd.start_div) begin
      rem_r     <= '0;
      bit_cnt_r <= CNT_WIDTH'(VALUE_WIDTH - 1);
    end else if (cmd.div_step) begin
      rem_r     <= fits ? (shifted - REM_WIDTH'(d_r)) : shifted;
      bit_cnt_r <= bit_cnt_r - CNT_WIDTH'(1);
    end

    if (cmd.out_load) begin
      is_prime_r <= cmd.res_val;
    end
  end

  always_comb begin
    sts.n_lt2     = n_r < VALUE_WIDTH'(2);
    sts.n_is2     = n_r == VALUE_WIDTH'(2);
    sts.n_even    = !n_r[0];
    sts.sq_gt_n   = sq_r > SQ_WIDTH'(n_r);
    sts.rem_zero  = rem_r == '0;
    sts.step_last = bit_cnt_r == '0;
  end

  assign is_prime = is_prime_r;

endmodule

@@ src/tdpt_ctrl.sv @@
// controller: sequences classification, bound check, division and result handoff
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tdpt_sts_t sts,
  output tdpt_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CLASSIFY,
    BOUND,
    DIVIDE,
    EVAL,
    FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.res_val   = res_r;
    in_ready      = 1'b0;
    case (state_r)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = CLASSIFY;
        end
      end
      CLASSIFY: begin
        if (sts.n_lt2) begin
          res_nxt   = 1'b0;
          state_nxt = FINISH;
        end else if (sts.n_is2) begin
          res_nxt   = 1'b1;
          state_nxt = FINISH;
        end else if (sts.n_even) begin
          res_nxt   = 1'b0;
          state_nxt = FINISH;
        end else begin
          state_nxt = BOUND;
        end
      end
      BOUND: begin
        if (sts.sq_gt_n) begin
          res_nxt   = 1'b1;
          state_nxt = FINISH;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = DIVIDE;
        end
      end
      DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = EVAL;
        end
      end
      EVAL: begin
        if (sts.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = BOUND;
        end
      end
      FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/trial_division_prime_test.sv @@
// top level of the trial division prime test
//
// in_ch carries one unsigned candidate per item (valid/ready, accepted when both are high).
// out_ch returns one is_prime bit per item, in order.
// The block works on one candidate at a time: in_ch.ready is high only while idle.
// Zero, one, two and even candidates are decided in the classify state, which passes
// them straight to the finish state to wait for the result register.
// An odd candidate n tries odd divisors d = 3, 5, ... while d*d <= n;
// each divisor passes through the shared bit-serial remainder unit (bound check,
// one candidate bit per cycle, evaluate), and the square is kept by incremental addition.
// The result sits in an output register, so the next candidate is accepted while an
// earlier result still waits; if out_ch stalls, the next result is held in the
// controller until the output register frees, and no new item is taken meanwhile.
// Synchronous active-low reset returns the controller to idle and empties the output.
module trial_division_prime_test import tdpt_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  tdpt_in_if.sink     in_ch,
  tdpt_out_if.source  out_ch
);

  tdpt_cmd_t cmd;
  tdpt_sts_t sts;

  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tdpt_dp u_dp (
    .clk       (clk),
    .candidate (in_ch.candidate),
    .cmd       (cmd),
    .sts       (sts),
    .is_prime  (out_ch.is_prime)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still ready after an item was accepted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while its item waits");

  a_div_within_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !sts.sq_gt_n)
    else $error("division running with divisor squared above candidate");
`endif

endmodule

@@ tb/trial_division_prime_test_checker.sv @@
// checker for the trial division prime test: predicts is_prime per candidate and compares results
module trial_division_prime_test_checker import tdpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tdpt_in_if   in_mon,
  tdpt_out_if  out_mon,
  output int   mismatch_count,
  output int   pending,
  output int   results_seen,
  output int   primes_seen
);

  bit expected_is_prime [$];

  function automatic bit primality_of(input logic [VALUE_WIDTH-1:0] candidate);
    longint unsigned n;
    longint unsigned d;
    n = 64'(candidate);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    mismatch_count = 0;
    pending        = 0;
    results_seen   = 0;
    primes_seen    = 0;
  end

  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_is_prime.push_back(primality_of(in_mon.candidate));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_is_prime.size() == 0) begin
          $error("is_prime: expected none outstanding, actual %0d", out_mon.is_prime);
          mismatch_count++;
        end else begin
          want = expected_is_prime.pop_front();
          results_seen++;
          if (out_mon.is_prime === 1'b1) primes_seen++;
          if (out_mon.is_prime !== want) begin
            $error("is_prime: expected %0d, actual %0d", want, out_mon.is_prime);
            mismatch_count++;
          end
        end
      end
      pending <= expected_is_prime.size();
    end
  end

endmodule

@@ tb/trial_division_prime_test_test.sv @@
// testbench top for the trial division prime test: clock, reset, candidate stimulus and verdict
module trial_division_prime_test_test import tdpt_pkg::*; ();

  localparam int RANDOM_PER_PHASE = 26;
  localparam int STALL_CYCLES     = 200_000;
  localparam int DRAIN_CYCLES     = 64;
  localparam int CYCLE_LIMIT      = 10_000_000;

  typedef enum {PHASE_BUSY_RX, PHASE_BUSY_TX, PHASE_STEADY} idle_phase_t;

  logic        clk;
  logic        rst_n;
  idle_phase_t phase;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned cycle_count;
  int          mismatch_count;
  int          pending;
  int          results_seen;
  int          primes_seen;

  logic [VALUE_WIDTH-1:0] corner_values [$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
    32'd97, 32'd121, 32'd65521, 32'd65535, 32'd65537,
    32'd16752649,     // 4093 squared, divisor reaches the bound exactly
    32'd67108859,     // prime just below 2^26
    32'd4294967291,   // largest 32-bit prime, square compare near the top
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555
  };

  tdpt_in_if  in_bus ();
  tdpt_out_if out_bus ();

  trial_division_prime_test uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  trial_division_prime_test_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .primes_seen    (primes_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [VALUE_WIDTH-1:0] pick_candidate();
    logic [VALUE_WIDTH-1:0] raw;
    int unsigned            kind;
    int unsigned            p;
    int unsigned            q;
    raw  = $urandom;
    kind = $urandom_range(99);
    if (kind < 30) begin
      return VALUE_WIDTH'($urandom_range(1023));
    end else if (kind < 50) begin
      return VALUE_WIDTH'(raw[15:0]);
    end else if (kind < 65) begin
      // odd semiprime-like products with small factors
      p = 2 * $urandom_range(127) + 3;
      q = 2 * $urandom_range(127) + 3;
      return VALUE_WIDTH'(p * q);
    end else if (kind < 80) begin
      return {raw[VALUE_WIDTH-1:1], 1'b0};
    end else if (kind < 95) begin
      // full width, multiple of three so the search ends early
      return raw - raw % 3;
    end else begin
      return VALUE_WIDTH'(raw[23:0]);
    end
  endfunction

  task automatic send_candidate(input logic [VALUE_WIDTH-1:0] value);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.candidate <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // receiver: random hold-offs, plus one long stall when the steady phase begins
  initial begin
    int unsigned stall_left;
    bit          stall_done;
    stall_left    = 0;
    stall_done    = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (phase == PHASE_STEADY && !stall_done) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned k;
    in_bus.valid      = 1'b0;
    in_bus.candidate  = '0;
    rst_n             = 1'b0;
    phase             = PHASE_BUSY_RX;
    sender_idle_pct   = 17;
    receiver_idle_pct = 59;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_values[i]) send_candidate(corner_values[i]);
    for (k = 0; k < RANDOM_PER_PHASE; k++) send_candidate(pick_candidate());

    phase             = PHASE_BUSY_TX;
    sender_idle_pct   = 59;
    receiver_idle_pct = 17;
    for (k = 0; k < RANDOM_PER_PHASE; k++) send_candidate(pick_candidate());

    phase             = PHASE_STEADY;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    for (k = 0; k < RANDOM_PER_PHASE; k++) send_candidate(pick_candidate());

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d corner candidates and %0d random ones over three idle profiles",
             corner_values.size(), 3 * RANDOM_PER_PHASE);
    $display("%0d results checked, %0d prime, one %0d-cycle output stall, %0d cycles",
             results_seen, primes_seen, STALL_CYCLES, cycle_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
